>>> rtl/core/indexed_list_engine_core_assert.svh
// Assertion macros used by the list engine datapath.
// Expects signals named clk and arst_n in the scope that uses them.
`ifndef INDEXED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// Used by ile_ctrl, ile_datapath, indexed_list_engine_core and tb; no dependencies.
package ile_pkg;

	localparam int ILE_CAPACITY = 64;

	typedef enum logic [2:0] {
		KIND_READ   = 3'd0,
		KIND_HEAD   = 3'd1,
		KIND_TAIL   = 3'd2,
		KIND_AT     = 3'd3,
		KIND_DELETE = 3'd4,
		KIND_CLEAR  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ_WAIT,
		ST_INS_LOOP,
		ST_INS_MOVE,
		ST_DEL_LOOP,
		ST_DEL_MOVE
	} state_t;

	typedef enum logic [1:0] {
		RADDR_POS,
		RADDR_PREV,
		RADDR_NEXT
	} raddr_sel_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_LOAD_COUNT,
		CUR_LOAD_POS,
		CUR_DEC,
		CUR_INC
	} cur_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef enum logic [1:0] {
		VAL_ZERO,
		VAL_MEM,
		VAL_MISS
	} val_sel_t;

	typedef struct packed {
		logic       latch;
		logic       rd_en;
		raddr_sel_t rd_sel;
		logic       wr_en;
		logic       wr_item;
		cur_op_t    cur_op;
		cnt_op_t    cnt_op;
		logic       respond;
		status_t    resp_status;
		val_sel_t   resp_val;
	} ile_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  pos_lt_count;
		logic  target_gt_count;
		logic  full;
		logic  cur_at_target;
		logic  cur_last;
	} ile_stat_t;

endpackage

>>> rtl/core/indexed_list_engine_core.sv
// Top level of the indexed list engine: an ordered list of signed 32-bit values.
// Depends on ile_pkg; instantiates ile_ctrl and ile_datapath.
//
// A command is taken at a rising edge where start is high and busy is low; busy stays
// high until the result is presented. Each command gives exactly one result, shown on
// read_value, status and list_length for a single cycle while done is high; the
// receiver cannot stall it, so it must capture the result in that cycle. Done rises
// after the decode and read-wait states for a read, after the decode and loop states
// for an insert or delete that moves nothing, and after the decode state alone for a
// clear or a rejected command; an insert or delete adds a read state and a write state
// for each stored entry it shifts by one place, since the single entry memory performs
// one read and then one write per move. busy falls in the cycle where done is high, so
// the next command may be accepted there. The list is empty after reset.
module indexed_list_engine_core import ile_pkg::*; #(
	parameter int CAPACITY = ILE_CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         kind,
	input  logic [7:0]                         position,
	input  logic signed [31:0]                 item_value,
	output logic                               done,
	output logic signed [31:0]                 read_value,
	output logic [1:0]                         status,
	output logic [$clog2(CAPACITY + 1) - 1:0]  list_length
);

	ile_cmd_t  cmd;
	ile_stat_t stat;

	ile_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	ile_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.position    (position),
		.item_value  (item_value),
		.done        (done),
		.read_value  (read_value),
		.status      (status),
		.list_length (list_length)
	);

endmodule

>>> rtl/core/ile_ctrl.sv
// Command sequencer of the indexed list engine.
// Depends on ile_pkg; drives ile_datapath through ile_cmd_t and reads ile_stat_t.
module ile_ctrl import ile_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ile_stat_t stat,
	output ile_cmd_t  cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.kind)
					KIND_READ: begin
						state_next = stat.pos_lt_count ? ST_READ_WAIT : ST_IDLE;
					end
					KIND_HEAD, KIND_TAIL, KIND_AT: begin
						state_next = (stat.target_gt_count || stat.full) ? ST_IDLE : ST_INS_LOOP;
					end
					KIND_DELETE: begin
						state_next = stat.pos_lt_count ? ST_DEL_LOOP : ST_IDLE;
					end
					default: begin
						state_next = ST_IDLE;
					end
				endcase
			end
			ST_READ_WAIT: begin
				state_next = ST_IDLE;
			end
			ST_INS_LOOP: begin
				state_next = stat.cur_at_target ? ST_IDLE : ST_INS_MOVE;
			end
			ST_INS_MOVE: begin
				state_next = ST_INS_LOOP;
			end
			ST_DEL_LOOP: begin
				state_next = stat.cur_last ? ST_IDLE : ST_DEL_MOVE;
			end
			ST_DEL_MOVE: begin
				state_next = ST_DEL_LOOP;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.rd_sel      = RADDR_POS;
		cmd.cur_op      = CUR_HOLD;
		cmd.cnt_op      = CNT_HOLD;
		cmd.resp_status = STATUS_DONE;
		cmd.resp_val    = VAL_ZERO;
		busy            = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.latch = start;
			end
			ST_DECODE: begin
				unique case (stat.kind)
					KIND_READ: begin
						if (stat.pos_lt_count) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RADDR_POS;
						end else begin
							cmd.respond     = 1'b1;
							cmd.resp_status = STATUS_RANGE;
							cmd.resp_val    = VAL_MISS;
						end
					end
					KIND_HEAD, KIND_TAIL, KIND_AT: begin
						if (stat.target_gt_count) begin
							cmd.respond     = 1'b1;
							cmd.resp_status = STATUS_RANGE;
						end else if (stat.full) begin
							cmd.respond     = 1'b1;
							cmd.resp_status = STATUS_FULL;
						end else begin
							cmd.cur_op = CUR_LOAD_COUNT;
						end
					end
					KIND_DELETE: begin
						if (stat.pos_lt_count) begin
							cmd.cur_op = CUR_LOAD_POS;
						end else begin
							cmd.respond     = 1'b1;
							cmd.resp_status = STATUS_RANGE;
						end
					end
					KIND_CLEAR: begin
						cmd.cnt_op  = CNT_CLR;
						cmd.respond = 1'b1;
					end
					default: begin
						cmd.respond = 1'b1;
					end
				endcase
			end
			ST_READ_WAIT: begin
				cmd.respond  = 1'b1;
				cmd.resp_val = VAL_MEM;
			end
			ST_INS_LOOP: begin
				if (stat.cur_at_target) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_item = 1'b1;
					cmd.cnt_op  = CNT_INC;
					cmd.respond = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RADDR_PREV;
				end
			end
			ST_INS_MOVE: begin
				cmd.wr_en  = 1'b1;
				cmd.cur_op = CUR_DEC;
			end
			ST_DEL_LOOP: begin
				if (stat.cur_last) begin
					cmd.cnt_op  = CNT_DEC;
					cmd.respond = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RADDR_NEXT;
				end
			end
			ST_DEL_MOVE: begin
				cmd.wr_en  = 1'b1;
				cmd.cur_op = CUR_INC;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/ile_datapath.sv
// Entry memory, length counter, cursor and result registers of the list engine.
// Depends on ile_pkg and indexed_list_engine_core_assert.svh; steered by ile_ctrl.
`include "indexed_list_engine_core_assert.svh"

module ile_datapath import ile_pkg::*; #(
	parameter int CAPACITY = ILE_CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ile_cmd_t                           cmd,
	output ile_stat_t                          stat,
	input  logic [2:0]                         kind,
	input  logic [7:0]                         position,
	input  logic signed [31:0]                 item_value,
	output logic                               done,
	output logic signed [31:0]                 read_value,
	output logic [1:0]                         status,
	output logic [$clog2(CAPACITY + 1) - 1:0]  list_length
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	logic [31:0]       mem [CAPACITY];
	logic [31:0]       rdata_q;
	logic [2:0]        kind_q;
	logic [7:0]        pos_q;
	logic [31:0]       item_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	logic [AW-1:0]     cursor_q;
	logic [AW-1:0]     raddr;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  count_ext;
	logic [CMP_W-1:0]  target;
	logic              done_q;
	logic [31:0]       rvalue_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  length_q;

	assign pos_ext   = CMP_W'(pos_q);
	assign count_ext = CMP_W'(count_q);

	always_comb begin
		unique case (kind_t'(kind_q))
			KIND_HEAD: target = '0;
			KIND_TAIL: target = count_ext;
			default:   target = pos_ext;
		endcase
	end

	assign stat.kind            = kind_t'(kind_q);
	assign stat.pos_lt_count    = (pos_ext < count_ext);
	assign stat.target_gt_count = (target > count_ext);
	assign stat.full            = (count_q == CNT_W'(CAPACITY));
	assign stat.cur_at_target   = (CMP_W'(cursor_q) == target);
	assign stat.cur_last        = ((CNT_W'(cursor_q) + CNT_W'(1)) == count_q);

	always_comb begin
		unique case (cmd.rd_sel)
			RADDR_PREV: raddr = cursor_q - AW'(1);
			RADDR_NEXT: raddr = cursor_q + AW'(1);
			default:    raddr = pos_ext[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cursor_q] <= cmd.wr_item ? item_q : rdata_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			pos_q  <= position;
			item_q <= item_value;
		end
		unique case (cmd.cur_op)
			CUR_LOAD_COUNT: cursor_q <= count_q[AW-1:0];
			CUR_LOAD_POS:   cursor_q <= pos_ext[AW-1:0];
			CUR_DEC:        cursor_q <= cursor_q - AW'(1);
			CUR_INC:        cursor_q <= cursor_q + AW'(1);
			default:        cursor_q <= cursor_q;
		endcase
	end

	always_comb begin
		unique case (cmd.cnt_op)
			CNT_INC: count_next = count_q + CNT_W'(1);
			CNT_DEC: count_next = count_q - CNT_W'(1);
			CNT_CLR: count_next = '0;
			default: count_next = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			status_q <= cmd.resp_status;
			length_q <= count_next;
			unique case (cmd.resp_val)
				VAL_MEM:  rvalue_q <= rdata_q;
				VAL_MISS: rvalue_q <= '1;
				default:  rvalue_q <= '0;
			endcase
		end
	end

	assign done        = done_q;
	assign read_value  = rvalue_q;
	assign status      = status_q;
	assign list_length = length_q;

	`ILE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "length above capacity")
	`ILE_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held two cycles")
	`ILE_ASSERT_NOW(a_full_len, done_q && (status_q == STATUS_FULL), length_q == CNT_W'(CAPACITY), "full reported on a list that is not full")
	`ILE_ASSERT_NOW(a_write_on_move, cmd.wr_en && !cmd.wr_item, $past(cmd.rd_en), "entry moved without a prior read")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for indexed_list_engine_core, the ordered list of signed values.
// Depends on ile_pkg for the command kinds and status codes and on indexed_list_engine_core.
// A predictor of the list runs beside the block and every result is checked against it.
module tb;
	import ile_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = ILE_CAPACITY;
	localparam int RANDOM_CMDS = 1525;
	localparam int DRAIN_CYCLES = 140;

	typedef struct packed {
		kind_t             op;
		logic [7:0]        pos;
		logic signed [31:0] val;
	} list_cmd_t;

	typedef struct packed {
		logic signed [31:0] value;
		status_t            stat;
		logic [6:0]         length;
	} list_reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         kind = KIND_READ;
	logic [7:0]         position = '0;
	logic signed [31:0] item_value = '0;
	logic               done;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic [6:0]         list_length;

	list_cmd_t   pending_cmds[$];
	list_reply_t awaited_replies[$];
	logic signed [31:0] list_store[DEPTH];
	int list_fill = 0;
	int gen_len = 0;
	int mismatches = 0;
	logic took = 1'b0;
	int gap_left = 0;
	int burst_left = 0;

	indexed_list_engine_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.position   (position),
		.item_value (item_value),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.list_length(list_length)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic list_reply_t apply_command(list_cmd_t c);
		list_reply_t r;
		int target;
		r.value = '0;
		r.stat = STATUS_DONE;
		case (c.op)
			KIND_READ: begin
				if (c.pos < list_fill) begin
					r.value = list_store[c.pos];
				end else begin
					r.value = -1;
					r.stat = STATUS_RANGE;
				end
			end
			KIND_HEAD, KIND_TAIL, KIND_AT: begin
				if (c.op == KIND_HEAD) target = 0;
				else if (c.op == KIND_TAIL) target = list_fill;
				else target = c.pos;
				if (target > list_fill) begin
					r.stat = STATUS_RANGE;
				end else if (list_fill >= DEPTH) begin
					r.stat = STATUS_FULL;
				end else begin
					for (int i = list_fill; i > target; i--) list_store[i] = list_store[i - 1];
					list_store[target] = c.val;
					list_fill++;
				end
			end
			KIND_DELETE: begin
				if (c.pos < list_fill) begin
					for (int i = c.pos; i + 1 < list_fill; i++) list_store[i] = list_store[i + 1];
					list_fill--;
				end else begin
					r.stat = STATUS_RANGE;
				end
			end
			KIND_CLEAR: begin
				list_fill = 0;
			end
			default: begin
			end
		endcase
		r.length = list_fill[6:0];
		return r;
	endfunction

	// The length is tracked here as well so that positions can be aimed at the live list.
	task automatic queue_cmd(kind_t k, int p, logic [31:0] v);
		list_cmd_t c;
		c.op = k;
		c.pos = p[7:0];
		c.val = v;
		pending_cmds.push_back(c);
		case (k)
			KIND_HEAD, KIND_TAIL: if (gen_len < DEPTH) gen_len++;
			KIND_AT: if (p <= gen_len && gen_len < DEPTH) gen_len++;
			KIND_DELETE: if (p < gen_len) gen_len--;
			KIND_CLEAR: gen_len = 0;
			default: begin
			end
		endcase
	endtask

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	always @(negedge clk) begin : driver
		list_cmd_t c;
		if (!arst_n || (start && !took)) begin
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left--;
		end else if (pending_cmds.size() != 0) begin
			c = pending_cmds.pop_front();
			kind <= c.op;
			position <= c.pos;
			item_value <= c.val;
			start <= 1'b1;
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 20);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
			end
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin : monitor
		list_reply_t want;
		list_cmd_t c;
		if (arst_n) begin
			if (done) begin
				if (awaited_replies.size() == 0) begin
					flag_mismatch("unexpected transfer", read_value, '0);
				end else begin
					want = awaited_replies.pop_front();
					if (read_value !== want.value) flag_mismatch("read_value", read_value, want.value);
					if (status !== want.stat) flag_mismatch("status", status, want.stat);
					if (list_length !== want.length)
						flag_mismatch("list_length", list_length, want.length);
				end
			end
			if (start && !busy) begin
				c.op = kind_t'(kind);
				c.pos = position;
				c.val = item_value;
				awaited_replies.push_back(apply_command(c));
			end
			took <= start && !busy;
		end else begin
			took <= 1'b0;
		end
	end

	initial begin : stimulus
		int mode;
		int mode_left;
		int rd_w;
		int del_w;
		int r;
		int p;
		kind_t k;
		logic [31:0] v;

		queue_cmd(KIND_READ, 0, 0);
		queue_cmd(KIND_DELETE, 0, 0);
		queue_cmd(KIND_AT, 1, 32'h1111_1111);
		queue_cmd(KIND_AT, 0, 32'h0000_0005);
		queue_cmd(KIND_HEAD, 0, 32'h7fff_ffff);
		queue_cmd(KIND_TAIL, 0, 32'h8000_0000);
		queue_cmd(KIND_AT, 1, 32'hffff_ffff);
		queue_cmd(KIND_AT, 4, 32'h0000_0000);
		queue_cmd(KIND_AT, 6, 32'h2222_2222);
		for (int i = 0; i < 6; i++) queue_cmd(KIND_READ, i, 0);
		queue_cmd(KIND_READ, 255, 0);
		queue_cmd(KIND_DELETE, 255, 0);
		queue_cmd(KIND_DELETE, 0, 0);
		queue_cmd(KIND_DELETE, 3, 0);
		queue_cmd(KIND_DELETE, 1, 0);
		queue_cmd(KIND_READ, 0, 0);
		queue_cmd(KIND_READ, 1, 0);
		queue_cmd(KIND_CLEAR, 0, 0);
		queue_cmd(KIND_READ, 0, 0);
		queue_cmd(KIND_TAIL, 0, 32'h5a5a_5a5a);
		queue_cmd(KIND_AT, 255, 32'ha5a5_a5a5);

		// Random traffic alternates between filling, draining and mixed stretches so that
		// the list regularly runs full and empty.
		mode = 0;
		mode_left = 0;
		rd_w = 15;
		del_w = 10;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (mode_left == 0) begin
				mode = (n == 0) ? 0 : $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
				case (mode)
					0: begin rd_w = 15; del_w = 10; end
					1: begin rd_w = 20; del_w = 55; end
					default: begin rd_w = 30; del_w = 30; end
				endcase
			end
			mode_left--;
			r = $urandom_range(0, 99);
			if (r < 1) k = KIND_CLEAR;
			else if (r < 1 + rd_w) k = KIND_READ;
			else if (r < 1 + rd_w + del_w) k = KIND_DELETE;
			else k = kind_t'($urandom_range(1, 3));
			r = $urandom_range(0, 9);
			if (r == 0) p = $urandom_range(0, 255);
			else if (r == 1) p = gen_len;
			else if (k == KIND_AT) p = $urandom_range(0, gen_len);
			else if (gen_len == 0) p = 0;
			else p = $urandom_range(0, gen_len - 1);
			case ($urandom_range(0, 11))
				0: v = 32'h8000_0000;
				1: v = 32'h7fff_ffff;
				2: v = 32'hffff_ffff;
				3: v = 32'h0000_0000;
				default: v = $urandom;
			endcase
			queue_cmd(k, p, v);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start || awaited_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#(25_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> indexed_list_engine_core.f
+incdir+rtl/core
rtl/core/ile_pkg.sv
rtl/core/ile_ctrl.sv
rtl/core/ile_datapath.sv
rtl/core/indexed_list_engine_core.sv
tb/sv/tb.sv
